/* src/rptkey_pkg.sv */
package rptkey_pkg;

  localparam int PATTERN_DEPTH = 1024;
  localparam int PTR_W = $clog2(PATTERN_DEPTH);

  localparam int POS_W = 11;
  localparam int LEAD_W = 4;
  localparam int IDS_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [LEAD_W-1:0] LEAD_TICKS_RESET = LEAD_W'(10);
  localparam logic [IDS_W-1:0] MAX_IDS_RESET = IDS_W'(3);

  typedef enum logic [1:0] {
    MODE_RX_LEVEL = 2'd0,
    MODE_BIT_TICK = 2'd1,
    MODE_ID_TICK  = 2'd2,
    MODE_WRITE    = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ID_LENGTH  = 2'd0,
    CFG_ACK_LENGTH = 2'd1,
    CFG_LEAD_TICKS = 2'd2,
    CFG_MAX_IDS    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] mode;
    logic       receiver_idle;
    logic       pattern_select;
    logic [9:0] pattern_index;
    logic       pattern_bit;
  } in_item_t;

  typedef struct packed {
    logic ptt;
    logic tone_on;
    logic rx_led;
    logic id_active;
    logic ack_active;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  id_length;
    logic [POS_W-1:0]  ack_length;
    logic [LEAD_W-1:0] lead_ticks;
    logic [IDS_W-1:0]  max_ids;
  } cfg_t;

endpackage

/* src/rptkey_pattern_ram.sv */
module rptkey_pattern_ram (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [rptkey_pkg::PTR_W-1:0] wr_addr_i,
  input  logic                       wr_data_i,
  input  logic [rptkey_pkg::PTR_W-1:0] rd_addr_i,
  output logic                       rd_data_o
);
  import rptkey_pkg::*;

  logic mem [PATTERN_DEPTH];
  logic rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // write-first so a bit written now is seen by the next read
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/rptkey_core.sv */
module rptkey_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rptkey_pkg::cfg_t      cfg_i,
  input  logic                  in_acc_i,
  input  rptkey_pkg::in_item_t  in_item_i,
  output rptkey_pkg::out_item_t res_o
);
  import rptkey_pkg::*;

  logic [POS_W-1:0]  id_pos_q, id_pos_d, ack_pos_q, ack_pos_d;
  logic [LEAD_W-1:0] id_lead_q, id_lead_d, ack_lead_q, ack_lead_d;
  logic [IDS_W-1:0]  ids_q, ids_d;
  logic send_id_q, send_id_d, send_ack_q, send_ack_d;
  logic id_done_q, id_done_d, ack_done_q, ack_done_d;
  logic tx_q, tx_d, ticking_q, ticking_d;
  logic tone_q, tone_d, led_q, led_d;

  logic id_rd_bit, ack_rd_bit;
  logic id_bit, ack_bit;
  logic wr_id, wr_ack;
  logic idx_in_range;

  // pattern bits are prefetched at the position the next item will see
  rptkey_pattern_ram u_id_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_id),
    .wr_addr_i (PTR_W'(in_item_i.pattern_index)),
    .wr_data_i (in_item_i.pattern_bit),
    .rd_addr_i (PTR_W'(id_pos_d)),
    .rd_data_o (id_rd_bit)
  );

  rptkey_pattern_ram u_ack_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_ack),
    .wr_addr_i (PTR_W'(in_item_i.pattern_index)),
    .wr_data_i (in_item_i.pattern_bit),
    .rd_addr_i (PTR_W'(ack_pos_d)),
    .rd_data_o (ack_rd_bit)
  );

  assign idx_in_range = 32'(in_item_i.pattern_index) < PATTERN_DEPTH;
  assign wr_id  = in_acc_i && (mode_e'(in_item_i.mode) == MODE_WRITE) &&
                  !in_item_i.pattern_select && idx_in_range;
  assign wr_ack = in_acc_i && (mode_e'(in_item_i.mode) == MODE_WRITE) &&
                  in_item_i.pattern_select && idx_in_range;

  assign id_bit  = (32'(id_pos_q) < PATTERN_DEPTH) ? id_rd_bit : 1'b0;
  assign ack_bit = (32'(ack_pos_q) < PATTERN_DEPTH) ? ack_rd_bit : 1'b0;

  always_comb begin
    logic             run_id;
    logic             run_ack;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_nx;
    logic [POS_W-1:0] len;
    logic [LEAD_W-1:0] lead;
    logic             pbit;
    logic             finished;

    id_pos_d   = id_pos_q;
    ack_pos_d  = ack_pos_q;
    id_lead_d  = id_lead_q;
    ack_lead_d = ack_lead_q;
    ids_d      = ids_q;
    send_id_d  = send_id_q;
    send_ack_d = send_ack_q;
    id_done_d  = id_done_q;
    ack_done_d = ack_done_q;
    tx_d       = tx_q;
    ticking_d  = ticking_q;
    tone_d     = tone_q;
    led_d      = led_q;

    run_id   = ticking_q && send_id_q;
    run_ack  = ticking_q && !send_id_q && send_ack_q;
    pos      = run_id ? id_pos_q : ack_pos_q;
    lead     = run_id ? id_lead_q : ack_lead_q;
    len      = run_id ? cfg_i.id_length : cfg_i.ack_length;
    pbit     = run_id ? id_bit : ack_bit;
    pos_nx   = pos + POS_W'(1);
    finished = 1'b0;

    if (in_acc_i) begin
      unique case (mode_e'(in_item_i.mode))
        MODE_RX_LEVEL: begin
          led_d = in_item_i.receiver_idle;
          if (in_item_i.receiver_idle) begin
            if (!send_id_q && !ack_done_q && !id_done_q) begin
              send_ack_d = 1'b1;
              ticking_d  = 1'b1;
            end else if (id_done_q) begin
              id_done_d = 1'b0;
            end
            tx_d = 1'b0;
          end else begin
            tx_d       = 1'b1;
            ack_done_d = 1'b0;
            ids_d      = '0;
          end
        end
        MODE_BIT_TICK: begin
          if (run_id || run_ack) begin
            if (!tx_q) begin
              tx_d       = 1'b1;
              ack_done_d = 1'b0;
              lead       = '0;
            end else if (lead < cfg_i.lead_ticks) begin
              lead = lead + LEAD_W'(1);
            end else begin
              tone_d = pbit;
              if (pos_nx >= len) begin
                ticking_d = 1'b0;
                tx_d      = 1'b0;
                pos       = '0;
                finished  = 1'b1;
              end else begin
                pos = pos_nx;
              end
            end
            if (run_id) begin
              id_pos_d  = pos;
              id_lead_d = lead;
              if (finished) begin
                send_id_d = 1'b0;
                id_done_d = 1'b1;
              end
            end else begin
              ack_pos_d  = pos;
              ack_lead_d = lead;
              if (finished) begin
                send_ack_d = 1'b0;
                ack_done_d = 1'b1;
              end
            end
          end
        end
        MODE_ID_TICK: begin
          if (ids_q < cfg_i.max_ids) begin
            send_id_d = 1'b1;
            ticking_d = 1'b1;
            ids_d     = ids_q + IDS_W'(1);
          end
        end
        MODE_WRITE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_pos_q   <= '0;
      ack_pos_q  <= '0;
      id_lead_q  <= '0;
      ack_lead_q <= '0;
      ids_q      <= '0;
      send_id_q  <= 1'b0;
      send_ack_q <= 1'b0;
      id_done_q  <= 1'b0;
      ack_done_q <= 1'b0;
      tx_q       <= 1'b0;
      ticking_q  <= 1'b0;
      tone_q     <= 1'b0;
      led_q      <= 1'b1;
    end else begin
      id_pos_q   <= id_pos_d;
      ack_pos_q  <= ack_pos_d;
      id_lead_q  <= id_lead_d;
      ack_lead_q <= ack_lead_d;
      ids_q      <= ids_d;
      send_id_q  <= send_id_d;
      send_ack_q <= send_ack_d;
      id_done_q  <= id_done_d;
      ack_done_q <= ack_done_d;
      tx_q       <= tx_d;
      ticking_q  <= ticking_d;
      tone_q     <= tone_d;
      led_q      <= led_d;
    end
  end

  assign res_o.ptt        = tx_d;
  assign res_o.tone_on    = tone_d;
  assign res_o.rx_led     = led_d;
  assign res_o.id_active  = send_id_d;
  assign res_o.ack_active = send_ack_d;

endmodule

/* src/rptkey_out_buf.sv */
module rptkey_out_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  rptkey_pkg::out_item_t  item_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rptkey_pkg::out_item_t  out_item_o
);
  import rptkey_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_q, out_d, skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d  = skid_valid_q || push_i;
      out_d        = skid_valid_q ? skid_q : item_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* src/repeater_id_and_courtesy_keyer.sv */
// result: registered in the output buffer when its item is accepted
// throughput: one item per cycle while in_stall_o is low; the state
//   update and prefetched pattern bit read finish in the accepting cycle
// reset: control state, positions and counters clear, led level set,
//   registers return to their defaults; pattern stores are not cleared
module repeater_id_and_courtesy_keyer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rptkey_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rptkey_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  rptkey_pkg::in_item_t                  in_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output rptkey_pkg::out_item_t                 out_item_o
);
  import rptkey_pkg::*;

  cfg_t      cfg_q;
  logic      in_acc;
  logic      buf_full;
  out_item_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.id_length  <= '0;
      cfg_q.ack_length <= '0;
      cfg_q.lead_ticks <= LEAD_TICKS_RESET;
      cfg_q.max_ids    <= MAX_IDS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ID_LENGTH:  cfg_q.id_length  <= POS_W'(cfg_wdata_i);
        CFG_ACK_LENGTH: cfg_q.ack_length <= POS_W'(cfg_wdata_i);
        CFG_LEAD_TICKS: cfg_q.lead_ticks <= cfg_wdata_i[LEAD_W-1:0];
        CFG_MAX_IDS:    cfg_q.max_ids    <= cfg_wdata_i[IDS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i && !buf_full;

  rptkey_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_acc_i  (in_acc),
    .in_item_i (in_item_i),
    .res_o     (res)
  );

  rptkey_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .item_i      (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import rptkey_pkg::*;

  localparam int GEN_VIEW = 0;
  localparam int CHK_VIEW = 1;

  typedef struct packed {
    logic [PATTERN_DEPTH-1:0] id_bits;
    logic [PATTERN_DEPTH-1:0] ack_bits;
    logic [POS_W-1:0]         id_pos;
    logic [POS_W-1:0]         ack_pos;
    logic [LEAD_W-1:0]        id_lead;
    logic [LEAD_W-1:0]        ack_lead;
    logic [IDS_W-1:0]         id_count;
    logic                     send_id;
    logic                     send_ack;
    logic                     id_done;
    logic                     ack_done;
    logic                     tx;
    logic                     ticking;
    logic                     tone;
    logic                     led;
    cfg_t                     cfg;
  } keyer_state_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;

  // index 0 shadows the stimulus side, index 1 the checked side
  keyer_state_t keyer [2];
  in_item_t     event_q [$];
  out_item_t    key_out_q [$];
  bit [2*PATTERN_DEPTH-1:0] written = '0;
  out_item_t    want;
  bit           took = 1'b0;
  bit           quiet = 1'b0;
  int           errors = 0;
  int           issued = 0;
  int           in_gap = 0;
  int           in_run = 0;
  int           out_gap = 0;
  int           out_run = 0;

  repeater_id_and_courtesy_keyer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #6 clk_i = ~clk_i;

  function automatic void reset_view(int w);
    keyer[w] = '0;
    keyer[w].led = 1'b1;
    keyer[w].cfg.lead_ticks = LEAD_TICKS_RESET;
    keyer[w].cfg.max_ids = MAX_IDS_RESET;
  endfunction

  // one bit tick for the ID or the courtesy pattern; returns 1 when it finishes
  function automatic bit pattern_tick(int w, bit use_ack);
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  len;
    logic [LEAD_W-1:0] lead;
    bit                fin;
    pos = use_ack ? keyer[w].ack_pos : keyer[w].id_pos;
    lead = use_ack ? keyer[w].ack_lead : keyer[w].id_lead;
    len = use_ack ? keyer[w].cfg.ack_length : keyer[w].cfg.id_length;
    fin = 1'b0;
    if (!keyer[w].tx) begin
      keyer[w].ack_done = 1'b0;
      keyer[w].tx = 1'b1;
      lead = '0;
    end else if (lead < keyer[w].cfg.lead_ticks) begin
      lead = lead + LEAD_W'(1);
    end else begin
      if (pos < PATTERN_DEPTH) begin
        keyer[w].tone = use_ack ? keyer[w].ack_bits[pos[PTR_W-1:0]]
                                : keyer[w].id_bits[pos[PTR_W-1:0]];
      end else begin
        keyer[w].tone = 1'b0;
      end
      pos = pos + POS_W'(1);
      if (pos >= len) begin
        keyer[w].ticking = 1'b0;
        keyer[w].tx = 1'b0;
        pos = '0;
        fin = 1'b1;
      end
    end
    if (use_ack) begin
      keyer[w].ack_pos = pos;
      keyer[w].ack_lead = lead;
    end else begin
      keyer[w].id_pos = pos;
      keyer[w].id_lead = lead;
    end
    return fin;
  endfunction

  function automatic out_item_t keyer_step(int w, in_item_t it);
    out_item_t r;
    case (it.mode)
      MODE_RX_LEVEL: begin
        keyer[w].led = it.receiver_idle;
        if (it.receiver_idle) begin
          if (!keyer[w].send_id && !keyer[w].ack_done && !keyer[w].id_done) begin
            keyer[w].send_ack = 1'b1;
            keyer[w].ticking = 1'b1;
          end else if (keyer[w].id_done) begin
            keyer[w].id_done = 1'b0;
          end
          keyer[w].tx = 1'b0;
        end else begin
          keyer[w].ack_done = 1'b0;
          keyer[w].tx = 1'b1;
          keyer[w].id_count = '0;
        end
      end
      MODE_BIT_TICK: begin
        if (keyer[w].ticking) begin
          if (keyer[w].send_id) begin
            if (pattern_tick(w, 1'b0)) begin
              keyer[w].send_id = 1'b0;
              keyer[w].id_done = 1'b1;
            end
          end else if (keyer[w].send_ack) begin
            if (pattern_tick(w, 1'b1)) begin
              keyer[w].send_ack = 1'b0;
              keyer[w].ack_done = 1'b1;
            end
          end
        end
      end
      MODE_ID_TICK: begin
        if (keyer[w].id_count < keyer[w].cfg.max_ids) begin
          keyer[w].send_id = 1'b1;
          keyer[w].ticking = 1'b1;
          keyer[w].id_count = keyer[w].id_count + IDS_W'(1);
        end
      end
      default: begin
        if (it.pattern_select) begin
          keyer[w].ack_bits[it.pattern_index] = it.pattern_bit;
        end else begin
          keyer[w].id_bits[it.pattern_index] = it.pattern_bit;
        end
      end
    endcase
    r.ptt = keyer[w].tx;
    r.tone_on = keyer[w].tone;
    r.rx_led = keyer[w].led;
    r.id_active = keyer[w].send_id;
    r.ack_active = keyer[w].send_ack;
    return r;
  endfunction

  // pattern bit that the next bit tick would read: ack bits sit above the ID bits
  function automatic int tick_reads();
    if (!keyer[GEN_VIEW].ticking || !keyer[GEN_VIEW].tx) return -1;
    if (keyer[GEN_VIEW].send_id) begin
      if (keyer[GEN_VIEW].id_lead < keyer[GEN_VIEW].cfg.lead_ticks) return -1;
      if (keyer[GEN_VIEW].id_pos >= PATTERN_DEPTH) return -1;
      return int'(keyer[GEN_VIEW].id_pos);
    end
    if (keyer[GEN_VIEW].send_ack) begin
      if (keyer[GEN_VIEW].ack_lead < keyer[GEN_VIEW].cfg.lead_ticks) return -1;
      if (keyer[GEN_VIEW].ack_pos >= PATTERN_DEPTH) return -1;
      return PATTERN_DEPTH + int'(keyer[GEN_VIEW].ack_pos);
    end
    return -1;
  endfunction

  function automatic in_item_t any_event();
    in_item_t e;
    e = in_item_t'($urandom);
    return e;
  endfunction

  function automatic in_item_t mode_event(mode_e m);
    in_item_t e;
    e = any_event();
    e.mode = m;
    return e;
  endfunction

  function automatic in_item_t rx_event(bit idle);
    in_item_t e;
    e = mode_event(MODE_RX_LEVEL);
    e.receiver_idle = idle;
    return e;
  endfunction

  function automatic in_item_t write_event(bit sel, int idx, bit value);
    in_item_t e;
    e = mode_event(MODE_WRITE);
    e.pattern_select = sel;
    e.pattern_index = idx[PTR_W-1:0];
    e.pattern_bit = value;
    return e;
  endfunction

  task automatic push_event(in_item_t it);
    if (it.mode == MODE_WRITE) written[{it.pattern_select, it.pattern_index}] = 1'b1;
    void'(keyer_step(GEN_VIEW, it));
    event_q.push_back(it);
    issued++;
  endtask

  // a tick that would read a never written bit gets that bit written first
  task automatic issue(in_item_t it);
    int r;
    if (it.mode == MODE_BIT_TICK) begin
      r = tick_reads();
      if (r >= 0 && !written[r]) begin
        push_event(write_event(r >= PATTERN_DEPTH, r % PATTERN_DEPTH, 1'($urandom)));
      end
    end
    push_event(it);
  endtask

  task automatic drain(bit noisy);
    int guard;
    guard = 0;
    while (keyer[GEN_VIEW].ticking && guard < 5000) begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        issue(any_event());
      end else begin
        issue(mode_event(MODE_BIT_TICK));
      end
      guard++;
    end
  endtask

  task automatic episode();
    int k;
    k = $urandom_range(0, 9);
    if (k <= 3) begin
      issue(rx_event(1'b0));
      repeat ($urandom_range(0, 3)) issue(any_event());
      issue(rx_event(1'b1));
      drain(1'b1);
    end else if (k <= 5) begin
      issue(mode_event(MODE_ID_TICK));
      if ($urandom_range(0, 2) == 0) begin
        issue(rx_event(1'b0));
        issue(rx_event(1'b1));
      end
      drain(1'b1);
    end else if (k == 6) begin
      repeat ($urandom_range(1, 6)) issue(mode_event(MODE_WRITE));
    end else begin
      repeat ($urandom_range(1, 8)) issue(any_event());
    end
  endtask

  task automatic run_phase(int n);
    int start;
    start = issued;
    while (issued - start < n) episode();
    drain(1'b1);
  endtask

  task automatic wait_idle();
    while (event_q.size() != 0 || in_valid || key_out_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    for (int v = 0; v < 2; v++) begin
      case (idx)
        CFG_ID_LENGTH:  keyer[v].cfg.id_length = value;
        CFG_ACK_LENGTH: keyer[v].cfg.ack_length = value;
        CFG_LEAD_TICKS: keyer[v].cfg.lead_ticks = value[LEAD_W-1:0];
        default:        keyer[v].cfg.max_ids = value[IDS_W-1:0];
      endcase
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int id_len, int ack_len, int lead, int max_id);
    write_reg(CFG_ID_LENGTH, CFG_DATA_W'(id_len));
    write_reg(CFG_ACK_LENGTH, CFG_DATA_W'(ack_len));
    write_reg(CFG_LEAD_TICKS, CFG_DATA_W'(lead));
    write_reg(CFG_MAX_IDS, CFG_DATA_W'(max_id));
  endtask

  task automatic check_field(string name, logic want_v, logic got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0b, got %0b", name, want_v, got_v);
      errors++;
    end
  endtask

  // monitor: results first, then the input item taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (key_out_q.size() == 0) begin
          $error("result with no item pending: %b", out_item);
          errors++;
        end else begin
          want = key_out_q.pop_front();
          check_field("ptt", want.ptt, out_item.ptt);
          check_field("tone_on", want.tone_on, out_item.tone_on);
          check_field("rx_led", want.rx_led, out_item.rx_led);
          check_field("id_active", want.id_active, out_item.id_active);
          check_field("ack_active", want.ack_active, out_item.ack_active);
        end
      end
      took = in_valid && !in_stall;
      if (took) begin
        key_out_q.push_back(keyer_step(CHK_VIEW, in_item));
        void'(event_q.pop_front());
      end
    end
  end

  // driver: input items and output stall, changed on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || took) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (event_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet && in_run == 0) begin
          in_gap = $urandom_range(0, 16);
          in_run = $urandom_range(0, 60);
          in_valid <= 1'b0;
        end else begin
          if (in_run > 0) in_run--;
          in_valid <= 1'b1;
          in_item <= event_q[0];
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && out_run == 0) begin
        out_gap = $urandom_range(0, 16);
        out_run = $urandom_range(0, 60);
        out_stall <= 1'b1;
      end else begin
        if (out_run > 0) out_run--;
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    reset_view(GEN_VIEW);
    reset_view(CHK_VIEW);
    in_run = $urandom_range(0, 60);
    out_run = $urandom_range(0, 60);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: defaults, zero lengths, stopped ticker, id limit
    issue(mode_event(MODE_BIT_TICK));
    issue(write_event(1'b0, PATTERN_DEPTH - 1, 1'b1));
    issue(write_event(1'b1, 0, 1'b1));
    issue(rx_event(1'b0));
    issue(rx_event(1'b1));
    drain(1'b0);
    repeat (4) issue(mode_event(MODE_ID_TICK));
    issue(rx_event(1'b0));
    issue(rx_event(1'b1));
    run_phase(150);

    set_config(3, 2, 0, 7);
    run_phase(170);

    set_config(0, 17, 15, 0);
    run_phase(130);

    set_config(40, 1, 1, 2);
    run_phase(200);

    // longer patterns with the longest lead and no idling
    wait_idle();
    quiet = 1'b1;
    set_config(48, 32, 15, 1);
    issue(rx_event(1'b0));
    issue(mode_event(MODE_ID_TICK));
    issue(rx_event(1'b1));
    drain(1'b0);
    repeat (2) begin
      issue(rx_event(1'b0));
      issue(rx_event(1'b1));
    end
    drain(1'b0);

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
